// ----- rtl/bezier_curve_sampler_assert.svh -----
// assertion macros for the bezier curve sampler port checker
`ifndef BEZIER_CURVE_SAMPLER_ASSERT_SVH
`define BEZIER_CURVE_SAMPLER_ASSERT_SVH

// same-cycle implication, masked during reset
`define BCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define BCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after reset is seen
`define BCS_ASSERT_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bcs_pkg.sv -----
// shared types and constants of the bezier curve sampler
package bcs_pkg;

  localparam int COORD_W    = 32;
  localparam int INDEX_W    = 3;
  localparam int SAMPLE_W   = 7;
  localparam int COUNT_W    = 4;
  localparam int FRAC_W     = 16;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_LEVEL,
    ST_FINISH,
    ST_DELIVER
  } state_t;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef struct packed {
    logic valid;
    logic last;
  } lerp_tag_t;

endpackage

// ----- rtl/bezier_curve_sampler.sv -----
// bezier curve sampler top: point ram, work ram, level sequencer and shared lerp pipeline
// a sample over n >= 2 points makes one ram read per point of each level and stalls the
// short last levels until entry 0 of the previous level is written; a single point is
// read once and passed through; a load or a sample on an empty curve stays in idle;
// input is ready again in the cycle the result appears, unless the output is still full
// reset is synchronous: point count zero, all points read as zero, no result pending
module bezier_curve_sampler #(
  parameter int MAX_POINTS = 8,
  parameter int SAMPLES    = 100,
  parameter int COORD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // point_index, point_x, point_y, sample_index, zero pad
  input  logic [bcs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // action
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // curve_x, curve_y, sample_echo, zero pad
  output logic [bcs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bcs_pkg::COUNT_W-1:0]        cfg_data
);

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CW    = COORD_BITS;
  localparam int T_DEPTH = 1 << bcs_pkg::SAMPLE_W;

  // input fields
  bcs_pkg::action_t              in_action;
  logic [bcs_pkg::INDEX_W-1:0]   in_index;
  logic [bcs_pkg::COORD_W-1:0]   in_x;
  logic [bcs_pkg::COORD_W-1:0]   in_y;
  logic [bcs_pkg::SAMPLE_W-1:0]  in_sample;
  logic                          in_fire;

  assign in_action = bcs_pkg::action_t'(s_axis_tuser[0]);
  assign in_index  = s_axis_tdata[2:0];
  assign in_x      = s_axis_tdata[34:3];
  assign in_y      = s_axis_tdata[66:35];
  assign in_sample = s_axis_tdata[73:67];
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  // t in q0.16 for each sample number
  logic [bcs_pkg::FRAC_W-1:0] t_rom [T_DEPTH];
  for (genvar g = 0; g < T_DEPTH; g++) begin : g_t_rom
    assign t_rom[g] = bcs_pkg::FRAC_W'(((g << bcs_pkg::FRAC_W) + SAMPLES / 2) / SAMPLES);
  end

  // registers
  bcs_pkg::state_t             state, state_next;
  logic [bcs_pkg::COUNT_W-1:0] point_count;
  logic [MAX_POINTS-1:0]       point_valid;
  logic [CNT_W-1:0]            lvl_len, lvl_len_next;
  logic [CNT_W-1:0]            rd_idx, rd_idx_next;
  logic                        first_lvl, first_lvl_next;
  logic                        wrote0;
  logic [bcs_pkg::FRAC_W-1:0]  t_q;
  logic [bcs_pkg::SAMPLE_W-1:0] k_q;
  logic                        rv_q;
  logic [AW-1:0]               rv_addr;
  logic                        rv_store;
  logic                        rv_valid;
  logic                        rv_last;
  logic                        rv_single;
  logic signed [CW-1:0]        prev_x, prev_y;
  logic signed [CW-1:0]        res_x, res_y;
  logic [bcs_pkg::OUT_DATA_W-1:0] out_data;

  // combinational
  logic [CNT_W-1:0]             n_eff;
  logic [bcs_pkg::SAMPLE_W-1:0] k_clamp;
  logic [31:0]                  idx_ext;
  logic                         load_we;
  logic [AW-1:0]                load_addr;
  logic                         rd_en, rd_store, rd_last, rd_single;
  logic [AW-1:0]                rd_addr;
  logic                         out_load;
  logic                         sample_start;
  logic                         res_done;
  logic [2*CW-1:0]              store_rdata, work_rdata, rsel;
  logic signed [CW-1:0]         rx, ry;
  bcs_pkg::lerp_tag_t           li_tag, lo_tag;
  logic [AW-1:0]                li_addr, lo_addr;
  logic signed [CW-1:0]         lo_x, lo_y;

  assign cfg_ready = 1'b1;

  assign n_eff = (32'(point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(point_count);
  assign k_clamp = (32'(in_sample) > SAMPLES - 1) ? bcs_pkg::SAMPLE_W'(SAMPLES - 1)
                                                  : in_sample;

  assign idx_ext   = 32'(in_index);
  assign load_addr = idx_ext[AW-1:0];
  assign load_we   = in_fire && (in_action == bcs_pkg::ACT_LOAD) && (idx_ext < MAX_POINTS);

  assign s_axis_tready = (state == bcs_pkg::ST_IDLE);

  always_comb begin
    state_next     = state;
    lvl_len_next   = lvl_len;
    rd_idx_next    = rd_idx;
    first_lvl_next = first_lvl;
    rd_en          = 1'b0;
    rd_addr        = '0;
    rd_store       = 1'b0;
    rd_last        = 1'b0;
    rd_single      = 1'b0;
    out_load       = 1'b0;
    sample_start   = 1'b0;
    case (state)
      bcs_pkg::ST_IDLE: begin
        if (in_fire && in_action == bcs_pkg::ACT_SAMPLE) begin
          sample_start = 1'b1;
          if (n_eff == CNT_W'(1)) begin
            state_next = bcs_pkg::ST_SINGLE;
          end else if (n_eff != '0) begin
            state_next     = bcs_pkg::ST_LEVEL;
            lvl_len_next   = n_eff - CNT_W'(1);
            rd_idx_next    = '0;
            first_lvl_next = 1'b1;
          end
        end
      end
      bcs_pkg::ST_SINGLE: begin
        rd_en      = 1'b1;
        rd_store   = 1'b1;
        rd_single  = 1'b1;
        state_next = bcs_pkg::ST_FINISH;
      end
      bcs_pkg::ST_LEVEL: begin
        // a later level may only start once entry 0 of the level before is written
        if (rd_idx != '0 || first_lvl || wrote0) begin
          rd_en    = 1'b1;
          rd_addr  = rd_idx[AW-1:0];
          rd_store = first_lvl;
          rd_last  = (lvl_len == CNT_W'(1));
          if (rd_idx == lvl_len) begin
            if (lvl_len == CNT_W'(1)) begin
              state_next = bcs_pkg::ST_FINISH;
            end else begin
              lvl_len_next   = lvl_len - CNT_W'(1);
              rd_idx_next    = '0;
              first_lvl_next = 1'b0;
            end
          end else begin
            rd_idx_next = rd_idx + CNT_W'(1);
          end
        end
      end
      bcs_pkg::ST_FINISH: begin
        if (res_done) begin
          state_next = bcs_pkg::ST_DELIVER;
        end
      end
      bcs_pkg::ST_DELIVER: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = bcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bcs_pkg::ST_IDLE;
      point_count   <= '0;
      point_valid   <= '0;
      lvl_len       <= '0;
      rd_idx        <= '0;
      first_lvl     <= 1'b0;
      wrote0        <= 1'b0;
      rv_q          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state     <= state_next;
      lvl_len   <= lvl_len_next;
      rd_idx    <= rd_idx_next;
      first_lvl <= first_lvl_next;
      rv_q      <= rd_en;
      if (cfg_valid) begin
        point_count <= cfg_data;
      end
      if (load_we) begin
        point_valid[load_addr] <= 1'b1;
      end
      if (rd_en && !rd_single && rd_addr == '0) begin
        wrote0 <= 1'b0;
      end
      if (lo_tag.valid && lo_addr == '0) begin
        wrote0 <= 1'b1;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_start) begin
      t_q <= t_rom[k_clamp];
      k_q <= k_clamp;
    end
    rv_addr   <= rd_addr;
    rv_store  <= rd_store;
    rv_valid  <= point_valid[rd_addr];
    rv_last   <= rd_last;
    rv_single <= rd_single;
    if (rv_q) begin
      prev_x <= rx;
      prev_y <= ry;
    end
    if (rv_q && rv_single) begin
      res_x <= rx;
      res_y <= ry;
    end else if (lo_tag.valid && lo_tag.last) begin
      res_x <= lo_x;
      res_y <= lo_y;
    end
    if (out_load) begin
      out_data <= {1'b0, k_q, 32'(res_y), 32'(res_x)};
    end
  end

  assign m_axis_tdata = out_data;

  // never-written points read as zero
  assign rsel = rv_store ? (rv_valid ? store_rdata : '0) : work_rdata;
  assign rx   = $signed(rsel[CW-1:0]);
  assign ry   = $signed(rsel[2*CW-1:CW]);

  assign res_done = (rv_q && rv_single) || (lo_tag.valid && lo_tag.last);

  assign li_tag.valid = rv_q && !rv_single && (rv_addr != '0);
  assign li_tag.last  = rv_last;
  assign li_addr      = rv_addr - AW'(1);

  bcs_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_POINTS)
  ) u_point_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata ({in_y[CW-1:0], in_x[CW-1:0]}),
    .raddr (rd_addr),
    .rdata (store_rdata)
  );

  bcs_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_POINTS)
  ) u_work_ram (
    .clk   (clk),
    .we    (lo_tag.valid),
    .waddr (lo_addr),
    .wdata ({lo_y, lo_x}),
    .raddr (rd_addr),
    .rdata (work_rdata)
  );

  bcs_lerp #(
    .CW (CW),
    .AW (AW)
  ) u_lerp (
    .clk      (clk),
    .rst      (rst),
    .t        (t_q),
    .in_tag   (li_tag),
    .in_addr  (li_addr),
    .a_x      (prev_x),
    .a_y      (prev_y),
    .b_x      (rx),
    .b_y      (ry),
    .out_tag  (lo_tag),
    .out_addr (lo_addr),
    .out_x    (lo_x),
    .out_y    (lo_y)
  );

endmodule

// ----- rtl/bcs_ram.sv -----
// generic single-write, single-read ram with registered read data
module bcs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bcs_lerp.sv -----
// two-stage rounded linear interpolation of x and y, a + t * (b - a) with t in q0.16
module bcs_lerp #(
  parameter int CW = 32,
  parameter int AW = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bcs_pkg::FRAC_W-1:0]   t,
  input  bcs_pkg::lerp_tag_t           in_tag,
  input  logic [AW-1:0]                in_addr,
  input  logic signed [CW-1:0]         a_x,
  input  logic signed [CW-1:0]         a_y,
  input  logic signed [CW-1:0]         b_x,
  input  logic signed [CW-1:0]         b_y,
  output bcs_pkg::lerp_tag_t           out_tag,
  output logic [AW-1:0]                out_addr,
  output logic signed [CW-1:0]         out_x,
  output logic signed [CW-1:0]         out_y
);

  localparam int DW = CW + 1;
  localparam int PW = DW + bcs_pkg::FRAC_W + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (bcs_pkg::FRAC_W - 1);

  bcs_pkg::lerp_tag_t s1_tag;
  bcs_pkg::lerp_tag_t s2_tag;
  logic [AW-1:0]      s1_addr;
  logic [AW-1:0]      s2_addr;
  logic signed [CW-1:0] s1_ax, s1_ay, s2_ax, s2_ay;
  logic signed [DW-1:0] diff_x, diff_y;
  logic signed [PW-1:0] prod_x, prod_y;
  logic signed [PW-1:0] rnd_x, rnd_y;
  logic signed [bcs_pkg::FRAC_W:0] t_s;

  assign t_s = $signed({1'b0, t});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
      s2_tag <= '0;
    end else begin
      s1_tag <= in_tag;
      s2_tag <= s1_tag;
    end
  end

  // difference stage
  always_ff @(posedge clk) begin
    s1_addr <= in_addr;
    s1_ax   <= a_x;
    s1_ay   <= a_y;
    diff_x  <= DW'(b_x) - DW'(a_x);
    diff_y  <= DW'(b_y) - DW'(a_y);
  end

  // product stage
  always_ff @(posedge clk) begin
    s2_addr <= s1_addr;
    s2_ax   <= s1_ax;
    s2_ay   <= s1_ay;
    prod_x  <= diff_x * t_s;
    prod_y  <= diff_y * t_s;
  end

  // round to nearest, ties upward, then add the base point
  assign rnd_x = prod_x + HALF;
  assign rnd_y = prod_y + HALF;

  assign out_tag  = s2_tag;
  assign out_addr = s2_addr;
  assign out_x    = s2_ax + $signed(rnd_x[CW+bcs_pkg::FRAC_W-1:bcs_pkg::FRAC_W]);
  assign out_y    = s2_ay + $signed(rnd_y[CW+bcs_pkg::FRAC_W-1:bcs_pkg::FRAC_W]);

endmodule

// ----- rtl/bcs_checker.sv -----
// port-level checker for the bezier curve sampler, bound to the top level
`include "bezier_curve_sampler_assert.svh"

module bcs_checker #(
  parameter int SAMPLES = 100
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [0:0]                     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [bcs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  `BCS_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed or dropped while stalled")
  `BCS_ASSERT_NOW(a_echo_range, clk, rst, m_axis_tvalid, 32'(m_axis_tdata[70:64]) <= SAMPLES - 1, "sample echo beyond last sample")
  `BCS_ASSERT_RESET(a_reset_empty, clk, rst, !m_axis_tvalid, "result pending after reset")
  `BCS_ASSERT_NEXT(a_load_ready, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == bcs_pkg::ACT_LOAD), s_axis_tready, "load transaction blocked the input")

endmodule

bind bezier_curve_sampler bcs_checker #(.SAMPLES(SAMPLES)) u_bcs_checker (.*);

// ----- sim/bezier_curve_sampler_checker.sv -----
// checker for the bezier curve sampler: watches all channels, predicts curve points, compares
module bezier_curve_sampler_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [bcs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [0:0]                     s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [bcs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bcs_pkg::COUNT_W-1:0]    cfg_data,
  output int                             error_count,
  output int                             expected_left,
  output int                             points_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POINTS  = 8;
  localparam int SAMPLES     = 100;
  localparam int CW          = bcs_pkg::COORD_W;
  localparam int X_LSB       = bcs_pkg::INDEX_W;
  localparam int Y_LSB       = X_LSB + CW;
  localparam int K_LSB       = Y_LSB + CW;
  localparam int ECHO_LSB    = 2 * CW;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [CW-1:0]                 x;
    logic [CW-1:0]                 y;
    logic [bcs_pkg::SAMPLE_W-1:0]  echo;
  } curve_point_t;

  curve_point_t                  curve_q [$];
  curve_point_t                  got_pt;
  curve_point_t                  want_pt;
  logic signed [CW-1:0]          ctrl_x [MAX_POINTS];
  logic signed [CW-1:0]          ctrl_y [MAX_POINTS];
  logic [bcs_pkg::COUNT_W-1:0]   point_count;

  // one rounded interpolation step between two coordinates
  function automatic longint blend(input longint a, input longint b, input longint t);
    longint s;
    s = (65536 - t) * a + t * b + 32768;
    return s >>> 16;
  endfunction

  function automatic curve_point_t evaluate(input logic [bcs_pkg::SAMPLE_W-1:0] k_raw);
    curve_point_t pt;
    int           n;
    int           k;
    longint       t;
    longint       wx [MAX_POINTS];
    longint       wy [MAX_POINTS];
    n = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
    k = (k_raw > SAMPLES - 1) ? SAMPLES - 1 : int'(k_raw);
    t = (longint'(k) * 65536 + SAMPLES / 2) / SAMPLES;
    for (int i = 0; i < n; i++) begin
      wx[i] = ctrl_x[i];
      wy[i] = ctrl_y[i];
    end
    for (int r = 1; r < n; r++) begin
      for (int i = 0; i + r < n; i++) begin
        wx[i] = blend(wx[i], wx[i + 1], t);
        wy[i] = blend(wy[i], wy[i + 1], t);
      end
    end
    pt.x = CW'(wx[0]);
    pt.y = CW'(wy[0]);
    pt.echo = bcs_pkg::SAMPLE_W'(k);
    return pt;
  endfunction

  task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                 input logic [CW-1:0] want);
    if (error_count < MAX_REPORTS) begin
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      point_count = '0;
      foreach (ctrl_x[i]) begin
        ctrl_x[i] = '0;
        ctrl_y[i] = '0;
      end
      curve_q.delete();
    end else begin
      // results first: a result never belongs to the input taken on the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got_pt.x = m_axis_tdata[0 +: CW];
        got_pt.y = m_axis_tdata[CW +: CW];
        got_pt.echo = m_axis_tdata[ECHO_LSB +: bcs_pkg::SAMPLE_W];
        if (curve_q.size() == 0) begin
          report_mismatch("result with nothing expected", got_pt.x, '0);
        end else begin
          want_pt = curve_q.pop_front();
          if (got_pt.x !== want_pt.x) report_mismatch("curve_x", got_pt.x, want_pt.x);
          if (got_pt.y !== want_pt.y) report_mismatch("curve_y", got_pt.y, want_pt.y);
          if (got_pt.echo !== want_pt.echo) begin
            report_mismatch("sample_echo", CW'(got_pt.echo), CW'(want_pt.echo));
          end
          points_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        point_count = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (bcs_pkg::action_t'(s_axis_tuser[0]) == bcs_pkg::ACT_LOAD) begin
          ctrl_x[s_axis_tdata[0 +: bcs_pkg::INDEX_W]] = s_axis_tdata[X_LSB +: CW];
          ctrl_y[s_axis_tdata[0 +: bcs_pkg::INDEX_W]] = s_axis_tdata[Y_LSB +: CW];
        end else if (point_count != 0) begin
          curve_q.push_back(evaluate(s_axis_tdata[K_LSB +: bcs_pkg::SAMPLE_W]));
        end
      end
    end
    expected_left = curve_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
// testbench top for the bezier curve sampler: stimulus, handshake timing and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POINTS    = 8;
  localparam int RANDOM_ITEMS  = 950;
  localparam int SETTLE_CYCLES = 60;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int CW            = bcs_pkg::COORD_W;

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [bcs_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]                     s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [bcs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [bcs_pkg::COUNT_W-1:0]    cfg_data;

  int                             error_count;
  int                             expected_left;
  int                             points_checked;
  int                             cycle_count;
  int                             load_count;
  int                             sample_count;
  int                             setting_count;
  int                             item_count;
  int                             hold;
  bit                             quiet;
  logic [bcs_pkg::COUNT_W-1:0]    current_count;

  bezier_curve_sampler i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  bezier_curve_sampler_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .error_count    (error_count),
    .expected_left  (expected_left),
    .points_checked (points_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, expected_left);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return CW'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
      default: return $urandom;
    endcase
  endfunction

  // result side: random stall after each transaction
  initial begin
    m_axis_tready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) hold = draw_gap();
      @(negedge clk);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input bcs_pkg::action_t act, input logic [2:0] idx,
                           input logic [CW-1:0] x, input logic [CW-1:0] y,
                           input logic [bcs_pkg::SAMPLE_W-1:0] k);
    int                            gap;
    logic [bcs_pkg::IN_DATA_W-1:0] word;
    gap = draw_gap();
    word = '0;
    word[0 +: bcs_pkg::INDEX_W] = idx;
    word[bcs_pkg::INDEX_W +: CW] = x;
    word[bcs_pkg::INDEX_W + CW +: CW] = y;
    word[bcs_pkg::INDEX_W + 2 * CW +: bcs_pkg::SAMPLE_W] = k;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    s_axis_tuser <= act;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic load_point(input logic [2:0] idx, input logic [CW-1:0] x,
                            input logic [CW-1:0] y);
    send_item(bcs_pkg::ACT_LOAD, idx, x, y, bcs_pkg::SAMPLE_W'($urandom));
    load_count++;
    item_count++;
  endtask

  task automatic request_sample(input logic [bcs_pkg::SAMPLE_W-1:0] k);
    send_item(bcs_pkg::ACT_SAMPLE, 3'($urandom), $urandom, $urandom, k);
    if (current_count != 0) begin
      sample_count++;
      item_count++;
    end
  endtask

  // stop sending, let every expected result arrive, then let the block go quiet
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(input logic [bcs_pkg::COUNT_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    current_count = value;
    setting_count++;
  endtask

  initial begin
    int                          used;
    int                          burst;
    logic [bcs_pkg::COUNT_W-1:0] cnt;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    current_count = '0;
    quiet = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: empty curve, single point, full degree with extremes, oversized count, clamping
    write_count(0);
    request_sample(0);
    write_count(1);
    load_point(0, 32'h7fff_ffff, 32'h8000_0000);
    request_sample(0);
    request_sample(127);
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (i % 2 == 0) load_point(3'(i), 32'h7fff_ffff, 32'h8000_0000);
      else load_point(3'(i), 32'h8000_0000, 32'h7fff_ffff);
    end
    write_count(8);
    request_sample(0);
    request_sample(50);
    request_sample(99);
    request_sample(100);
    write_count(15);
    request_sample(127);
    write_count(2);
    request_sample(1);

    // random: reload the points in use, then mostly samples with some stray loads
    item_count = 0;
    while (item_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: cnt = 0;
        1: cnt = 8;
        2: cnt = 4'($urandom_range(9, 15));
        default: cnt = 4'($urandom_range(1, 8));
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      write_count(cnt);
      used = (cnt > MAX_POINTS) ? MAX_POINTS : int'(cnt);
      for (int i = 0; i < used; i++) load_point(3'(i), rand_coord(), rand_coord());
      burst = (cnt == 0) ? 4 : $urandom_range(8, 30);
      repeat (burst) begin
        if ($urandom_range(0, 9) == 0) begin
          load_point(3'($urandom), rand_coord(), rand_coord());
        end else if ($urandom_range(0, 9) == 0) begin
          request_sample(7'($urandom_range(100, 127)));
        end else begin
          request_sample(7'($urandom_range(0, 99)));
        end
      end
    end
    quiet = 1'b0;
    drain();

    $display("stimulus: %0d point loads, %0d served sample requests, %0d point-count writes",
             load_count, sample_count, setting_count);
    $display("compared %0d curve points, %0d mismatches", points_checked, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
